// ===== src/drf_pkg.sv =====
// Shared types, constants and command codes of the dirty-row refresh engine.
package drf_pkg;

   // default store geometry
   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 8;

   // command codes
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;
   localparam logic [1:0] FUNC_PULL  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;

   // register reset values
   localparam logic [6:0] COLUMNS_RESET = 7'd20;
   localparam logic [3:0] ROWS_RESET    = 4'd4;

   // stream and fill bytes
   localparam logic [7:0] BYTE_ESC   = 8'hFE;
   localparam logic [7:0] BYTE_GOTO  = 8'h47;
   localparam logic [7:0] BYTE_COL1  = 8'h01;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH  = 8'h23;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [1:0] func;
      logic [6:0] column;
      logic [3:0] line;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       row_end;
      logic       flush_end;
   } rsp_type;

endpackage

// ===== src/drf_ram.sv =====
// Character store: one write port, one read port with registered read data.
module drf_ram #(
   parameter int DEPTH  = drf_pkg::MAX_COLS_DEF * drf_pkg::MAX_ROWS_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  drf_pkg::byte_type   wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output drf_pkg::byte_type   rd_data
);
   import drf_pkg::*;

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   // write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dirty_row_frame_refresh.sv =====
// Top level of the dirty-row character display refresh engine.
//
//   channel   ports                                   direction  handshake
//   request   start, busy, req_word                   in         start && !busy
//   response  rsp_valid, rsp_word                     out        one-cycle strobe
//   config    csr_valid, csr_ready, csr_index/data    in         valid && ready
//
// Write, ignored commands and header-byte pulls finish in S_IDLE; a character
// pull also passes through S_CHAR. A pull that ends a row also copies the row
// into the shadow and scans for the next dirty row (one compare per cycle on
// the shared comparator). Start scans the same way. Clear sweeps the frame
// store, one entry a cycle. After reset a sweep fills both stores while busy
// is high; config writes are taken at any time. Responses cannot be stalled.
module dirty_row_frame_refresh #(
   parameter int MAX_COLS = drf_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = drf_pkg::MAX_ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  drf_pkg::req_type req_word,
   output logic             rsp_valid,
   output drf_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_data
);
   import drf_pkg::*;

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CNT_W  = $clog2(MAX_COLS + 1);
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int POS_W  = $clog2(MAX_COLS + 4);

   // sequencer states
   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_CHAR  = 3'd3;
   localparam logic [2:0] S_COPY  = 3'd4;
   localparam logic [2:0] S_SCAN  = 3'd5;

   function automatic logic [ADDR_W-1:0] cell_addr(input int r, input int c);
      return ADDR_W'(r * MAX_COLS + c);
   endfunction

   logic [2:0]        state_ff, state_in;
   logic              flushing_ff, flushing_in;
   logic [ROW_W-1:0]  flush_row_ff, flush_row_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [RCNT_W-1:0] walk_row_ff, walk_row_in;
   logic [CNT_W-1:0]  walk_col_ff, walk_col_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [RCNT_W-1:0] cmp_row_ff, cmp_row_in;
   logic              copy_vld_ff, copy_vld_in;
   logic [COL_W-1:0]  copy_col_ff, copy_col_in;
   logic              scan_pull_ff, scan_pull_in;
   byte_type          hold_byte_ff, hold_byte_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [6:0]        cols_ff;
   logic [3:0]        rows_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;

   logic [CNT_W-1:0]  cols_n;
   logic [RCNT_W-1:0] rows_n;
   logic              accept;
   logic [COL_W-1:0]  char_idx;
   logic              wr_ok;

   logic              frame_we, shadow_we;
   logic [ADDR_W-1:0] frame_waddr, shadow_waddr, rd_addr;
   byte_type          frame_wdata, shadow_wdata, frame_q, shadow_q;

   // clamp the size registers into the usable range
   always_comb begin
      if (cols_ff == '0) begin
         cols_n = CNT_W'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         cols_n = CNT_W'(MAX_COLS);
      end else begin
         cols_n = CNT_W'(cols_ff);
      end
      if (rows_ff == '0) begin
         rows_n = RCNT_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         rows_n = RCNT_W'(MAX_ROWS);
      end else begin
         rows_n = RCNT_W'(rows_ff);
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign char_idx  = COL_W'(pos_ff - POS_W'(4));

   assign wr_ok = !flushing_ff && (req_word.column != '0) &&
                  (int'(req_word.column) <= int'(cols_n)) &&
                  (req_word.line != '0) && (int'(req_word.line) <= int'(rows_n));

   // frame store write port: sweep or character write
   always_comb begin
      frame_we    = 1'b0;
      frame_waddr = clr_addr_ff;
      frame_wdata = CHAR_SPACE;
      if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         frame_we = 1'b1;
      end else if (accept && req_word.func == FUNC_WRITE && wr_ok) begin
         frame_we    = 1'b1;
         frame_waddr = cell_addr(int'(req_word.line) - 1, int'(req_word.column) - 1);
         frame_wdata = req_word.char_code;
      end
   end

   // shadow store write port: reset fill or row copy
   always_comb begin
      shadow_we    = 1'b0;
      shadow_waddr = clr_addr_ff;
      shadow_wdata = CHAR_HASH;
      if (state_ff == S_INIT) begin
         shadow_we = 1'b1;
      end else if (state_ff == S_COPY && copy_vld_ff) begin
         shadow_we    = 1'b1;
         shadow_waddr = cell_addr(int'(flush_row_ff), int'(copy_col_ff));
         shadow_wdata = frame_q;
      end
   end

   // shared read address: walker in copy and scan, else the next character
   always_comb begin
      if (state_ff == S_SCAN || state_ff == S_COPY) begin
         rd_addr = cell_addr(int'(walk_row_ff), int'(walk_col_ff[COL_W-1:0]));
      end else begin
         rd_addr = cell_addr(int'(flush_row_ff), int'(char_idx));
      end
   end

   drf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_frame (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (frame_waddr),
      .wr_data (frame_wdata),
      .rd_addr (rd_addr),
      .rd_data (frame_q)
   );

   drf_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_shadow (
      .clock   (clock),
      .wr_en   (shadow_we),
      .wr_addr (shadow_waddr),
      .wr_data (shadow_wdata),
      .rd_addr (rd_addr),
      .rd_data (shadow_q)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      flushing_in  = flushing_ff;
      flush_row_in = flush_row_ff;
      pos_in       = pos_ff;
      walk_row_in  = walk_row_ff;
      walk_col_in  = walk_col_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_row_in   = cmp_row_ff;
      copy_vld_in  = copy_vld_ff;
      copy_col_in  = copy_col_ff;
      scan_pull_in = scan_pull_ff;
      hold_byte_in = hold_byte_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff) inside
         S_INIT, S_CLEAR: begin
            // sweep one entry a cycle
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_addr_in = '0;
               state_in    = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               unique case (req_word.func)
                  FUNC_CLEAR: begin
                     if (!flushing_ff) begin
                        state_in = S_CLEAR;
                     end
                  end
                  FUNC_START: begin
                     if (!flushing_ff) begin
                        walk_row_in  = '0;
                        walk_col_in  = '0;
                        cmp_vld_in   = 1'b0;
                        scan_pull_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  FUNC_PULL: begin
                     if (flushing_ff) begin
                        if (int'(pos_ff) >= 4) begin
                           // character read issued this cycle
                           state_in = S_CHAR;
                        end else begin
                           rsp_valid_in          = 1'b1;
                           rsp_word_in.row_end   = 1'b0;
                           rsp_word_in.flush_end = 1'b0;
                           case (pos_ff)
                              POS_W'(0): rsp_word_in.out_byte = BYTE_ESC;
                              POS_W'(1): rsp_word_in.out_byte = BYTE_GOTO;
                              POS_W'(2): rsp_word_in.out_byte = BYTE_COL1;
                              default:   rsp_word_in.out_byte = 8'(flush_row_ff) + 8'd1;
                           endcase
                           pos_in = pos_ff + POS_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_CHAR: begin
            if (int'(char_idx) + 1 >= int'(cols_n)) begin
               // row done: copy it into the shadow, then look for the next one
               hold_byte_in = frame_q;
               walk_row_in  = RCNT_W'(flush_row_ff);
               walk_col_in  = '0;
               copy_vld_in  = 1'b0;
               state_in     = S_COPY;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{out_byte: frame_q, row_end: 1'b0, flush_end: 1'b0};
               pos_in       = pos_ff + POS_W'(1);
               state_in     = S_IDLE;
            end
         end

         S_COPY: begin
            if (walk_col_ff < cols_n) begin
               copy_vld_in = 1'b1;
               copy_col_in = walk_col_ff[COL_W-1:0];
               walk_col_in = walk_col_ff + CNT_W'(1);
            end else begin
               copy_vld_in  = 1'b0;
               walk_row_in  = RCNT_W'(flush_row_ff) + RCNT_W'(1);
               walk_col_in  = '0;
               cmp_vld_in   = 1'b0;
               scan_pull_in = 1'b1;
               state_in     = S_SCAN;
            end
         end

         S_SCAN: begin
            if ((cmp_vld_ff && frame_q != shadow_q) || walk_row_ff >= rows_n) begin
               // scan ends: a hit on the pending compare, or nothing left
               state_in   = S_IDLE;
               cmp_vld_in = 1'b0;
               if (cmp_vld_ff && frame_q != shadow_q) begin
                  flushing_in  = 1'b1;
                  flush_row_in = ROW_W'(cmp_row_ff);
                  pos_in       = '0;
                  if (scan_pull_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = '{out_byte: hold_byte_ff, row_end: 1'b1,
                                      flush_end: 1'b0};
                  end
               end else if (scan_pull_ff) begin
                  flushing_in  = 1'b0;
                  flush_row_in = '0;
                  pos_in       = '0;
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{out_byte: hold_byte_ff, row_end: 1'b1,
                                   flush_end: 1'b1};
               end
            end else begin
               // issue the next cell to the comparator
               cmp_vld_in = 1'b1;
               cmp_row_in = walk_row_ff;
               if (walk_col_ff + CNT_W'(1) >= cols_n) begin
                  walk_col_in = '0;
                  walk_row_in = walk_row_ff + RCNT_W'(1);
               end else begin
                  walk_col_in = walk_col_ff + CNT_W'(1);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         flushing_ff  <= 1'b0;
         flush_row_ff <= '0;
         pos_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         copy_vld_ff  <= 1'b0;
         scan_pull_ff <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         cols_ff      <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
      end else begin
         state_ff     <= state_in;
         flushing_ff  <= flushing_in;
         flush_row_ff <= flush_row_in;
         pos_ff       <= pos_in;
         cmp_vld_ff   <= cmp_vld_in;
         copy_vld_ff  <= copy_vld_in;
         scan_pull_ff <= scan_pull_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         // take size register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COLUMNS) begin
               cols_ff <= csr_data;
            end else if (csr_index == CSR_ROWS) begin
               rows_ff <= csr_data[3:0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_row_ff  <= walk_row_in;
      walk_col_ff  <= walk_col_in;
      cmp_row_ff   <= cmp_row_in;
      copy_col_ff  <= copy_col_in;
      hold_byte_ff <= hold_byte_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
